FILE: rtl/lmat_pkg.sv
// Shared types and constants for the local mean adaptive threshold block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lmat_pkg;

    localparam int PIXEL_W      = 8;
    localparam int COL_OUT_W    = 10;
    localparam int ROW_W        = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int CMP_W        = 14;

    typedef logic [PIXEL_W-1:0]     pixel_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam cfg_index_t REG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic [COL_OUT_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic                 last_of_frame;
        logic                 has_result;
        logic                 lines_full;
    } item_tag_t;

endpackage

`default_nettype wire

FILE: rtl/lmat_line_mem.sv
// Line store memory: one word per image column, holding the pixels of the
// previous rows. Registered read port, one write port. Uses lmat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmat_line_mem #(
    parameter int DEPTH = 1024,
    parameter int LINES = 6
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]                  wr_addr,
    input  wire logic [LINES*lmat_pkg::PIXEL_W-1:0]        wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]                  rd_addr,
    output logic      [LINES*lmat_pkg::PIXEL_W-1:0]        rd_data
);
    import lmat_pkg::*;

    localparam int WORD_W = LINES * PIXEL_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/local_mean_adaptive_threshold.sv
// Local mean adaptive threshold over a (2*RADIUS+1)-square window, top level.
// Depends on lmat_pkg and lmat_line_mem.
//
// Pixels enter in raster order, one per clock while the output is not held; a
// result passes stage 1, stage 2, stage 3 and the output register. The rate
// is set by the line memory, which is read once and written once per pixel
// (registered read, same-column write forwarded). Column sums are kept in a
// delay line and the window sum is a running total, so the mean compare is a
// constant multiply and one compare. Only pixels at least RADIUS from every
// edge give a result; is_white is 1 when the pixel is at or below the
// truncated mean. The line memory needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module local_mean_adaptive_threshold #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 3
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire lmat_pkg::cfg_index_t             cfg_index,
    input  wire lmat_pkg::cfg_data_t              cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_start_of_frame,
    input  wire logic [lmat_pkg::PIXEL_W-1:0]     s_pixel,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [lmat_pkg::COL_OUT_W-1:0]   m_center_col,
    output logic      [lmat_pkg::ROW_W-1:0]       m_center_row,
    output logic                                  m_is_white,
    output logic                                  m_last_of_frame
);
    import lmat_pkg::*;

    localparam int SPAN   = 2 * RADIUS + 1;
    localparam int LINES  = 2 * RADIUS;
    localparam int AREA   = SPAN * SPAN;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CS_W   = $clog2(SPAN * 255 + 1);
    localparam int SUM_W  = $clog2(AREA * 255 + 1);
    localparam int WORD_W = LINES * PIXEL_W;

    // configuration
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake chain
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy_out;
    logic accept, adv1, adv2;

    assign rdy_out = !m_valid_reg || m_ready;
    assign rdy3    = !v3_reg || rdy_out;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign accept  = s_valid && rdy1;
    assign adv1    = v1_reg && rdy2;
    assign adv2    = v2_reg && rdy3;

    // position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic [CMP_W-1:0] w_eff, h_eff, c_ext, r_ext, c_inc, r_inc, width_ext, max_ext;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    item_tag_t        tag_in;

    always_comb begin
        c_cur     = s_start_of_frame ? '0 : col_reg;
        r_cur     = s_start_of_frame ? '0 : row_reg;
        width_ext = CMP_W'(width_reg);
        max_ext   = CMP_W'(MAX_WIDTH);
        if (width_ext == '0) begin
            w_eff = CMP_W'(1);
        end else if (width_ext > max_ext) begin
            w_eff = max_ext;
        end else begin
            w_eff = width_ext;
        end
        h_eff = (height_reg == '0) ? CMP_W'(1) : CMP_W'(height_reg);
        c_ext = CMP_W'(c_cur);
        r_ext = CMP_W'(r_cur);
        c_inc = c_ext + CMP_W'(1);
        r_inc = r_ext + CMP_W'(1);
        if (c_inc >= w_eff) begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : ROW_W'(r_inc);
        end else begin
            col_next = COL_W'(c_inc);
            row_next = r_cur;
        end
        tag_in.center_col    = COL_OUT_W'(c_ext - CMP_W'(RADIUS));
        tag_in.center_row    = ROW_W'(r_ext - CMP_W'(RADIUS));
        tag_in.last_of_frame = (r_ext == h_eff - CMP_W'(1)) && (c_ext == w_eff - CMP_W'(1));
        tag_in.has_result    = (r_ext >= CMP_W'(LINES)) && (c_ext >= CMP_W'(LINES));
        tag_in.lines_full    = (r_ext >= CMP_W'(LINES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory
    logic [COL_W-1:0]  col1_reg;
    logic [WORD_W-1:0] rd_word, line_word, wr_word;
    logic              fwd_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    lmat_line_mem #(
        .DEPTH (MAX_WIDTH),
        .LINES (LINES)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (adv1),
        .wr_addr (col1_reg),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (rd_word)
    );

    // stage 1: column assembly and column sum
    pixel_t    px1_reg;
    item_tag_t tag1_reg;
    logic [CS_W-1:0] colsum;
    pixel_t    center_dl_reg [RADIUS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_valid;
            if (s_valid) begin
                fwd_reg <= adv1 && (col1_reg == c_cur);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px1_reg      <= s_pixel;
            col1_reg     <= c_cur;
            tag1_reg     <= tag_in;
            fwd_word_reg <= wr_word;
        end
    end

    always_comb begin
        line_word = fwd_reg ? fwd_word_reg : rd_word;
        colsum    = '0;
        if (tag1_reg.lines_full) begin
            colsum = CS_W'(px1_reg);
            for (int k = 0; k < LINES; k++) begin
                colsum = colsum + CS_W'(line_word[k*PIXEL_W +: PIXEL_W]);
            end
        end
        for (int k = 0; k < LINES - 1; k++) begin
            wr_word[k*PIXEL_W +: PIXEL_W] = line_word[(k+1)*PIXEL_W +: PIXEL_W];
        end
        wr_word[(LINES-1)*PIXEL_W +: PIXEL_W] = px1_reg;
    end

    // stage 2: running window sum
    item_tag_t       tag2_reg;
    logic [CS_W-1:0] cs2_reg;
    pixel_t          center2_reg;
    logic [CS_W-1:0] csd_reg [SPAN];
    logic [SUM_W-1:0] sum_reg, sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            tag2_reg         <= tag1_reg;
            cs2_reg          <= colsum;
            center2_reg      <= center_dl_reg[RADIUS-1];
            center_dl_reg[0] <= line_word[RADIUS*PIXEL_W +: PIXEL_W];
            for (int i = 1; i < RADIUS; i++) begin
                center_dl_reg[i] <= center_dl_reg[i-1];
            end
        end
    end

    assign sum_next = sum_reg + SUM_W'(cs2_reg) - SUM_W'(csd_reg[SPAN-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            for (int i = 0; i < SPAN; i++) begin
                csd_reg[i] <= '0;
            end
        end else if (adv2) begin
            sum_reg    <= sum_next;
            csd_reg[0] <= cs2_reg;
            for (int i = 1; i < SPAN; i++) begin
                csd_reg[i] <= csd_reg[i-1];
            end
        end
    end

    // stage 3: mean compare, as AREA * center <= sum
    item_tag_t        tag3_reg;
    logic [SUM_W-1:0] sum3_reg, scaled_center;
    pixel_t           center3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg && tag2_reg.has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            tag3_reg    <= tag2_reg;
            sum3_reg    <= sum_next;
            center3_reg <= center2_reg;
        end
    end

    assign scaled_center = SUM_W'(center3_reg) * SUM_W'(AREA);

    // output register
    logic [COL_OUT_W-1:0] out_col_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic                 out_white_reg, out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy_out) begin
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out && v3_reg) begin
            out_col_reg   <= tag3_reg.center_col;
            out_row_reg   <= tag3_reg.center_row;
            out_white_reg <= (scaled_center <= sum3_reg);
            out_last_reg  <= tag3_reg.last_of_frame;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_center_col    = out_col_reg;
    assign m_center_row    = out_row_reg;
    assign m_is_white      = out_white_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for local_mean_adaptive_threshold: a table of directed frames, then
// random frames and geometries, every result checked against an in-bench 7x7 mean predictor
// or, for some table rows, a fixed is_white. Depends on lmat_pkg and the block's RTL.
module tb;
    import lmat_pkg::*;

    localparam int RADIUS          = 3;
    localparam int SPAN            = 2 * RADIUS + 1;
    localparam int LINES           = 2 * RADIUS;
    localparam int AREA            = SPAN * SPAN;
    localparam int MAX_WIDTH       = 1024;
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 12;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_ITEMS    = 300;
    localparam int WHITE_PREDICTED = -1;

    localparam cfg_index_t REG_SPARE_LO = 2'd2;
    localparam cfg_index_t REG_SPARE_HI = 2'd3;

    typedef enum logic [2:0] {
        PIX_CONST, PIX_IMPULSE, PIX_RAMP, PIX_CHECKER, PIX_NEAR, PIX_BINARY, PIX_RANDOM
    } pix_mode_t;

    typedef struct packed {
        logic                    write_geometry;
        logic [WIDTH_REG_W-1:0]  width_raw;
        logic [HEIGHT_REG_W-1:0] height_raw;
        pix_mode_t               mode;
        pixel_t                  level;
        logic [15:0]             pixels;
        logic                    sof_noise;
        int                      fixed_white;
    } scenario_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 white;
        logic                 last;
    } mark_t;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_we           = 1'b0;
    cfg_index_t           cfg_index        = REG_IMAGE_WIDTH;
    cfg_data_t            cfg_data         = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic                 s_start_of_frame = 1'b0;
    pixel_t               s_pixel          = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [COL_OUT_W-1:0] m_center_col;
    logic [ROW_W-1:0]     m_center_row;
    logic                 m_is_white;
    logic                 m_last_of_frame;

    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
    pixel_t                  line_mem [LINES][MAX_WIDTH];
    pixel_t                  win [SPAN][SPAN];
    int unsigned             col_cnt    = 0;
    int unsigned             row_cnt    = 0;
    mark_t                   pending_marks [$];
    int unsigned             err_count  = 0;
    int unsigned             idle_cycles = 0;
    int                      burst_left = 0;
    int                      stretch_left = 0;
    logic [15:0]             stall_word = 16'hFFFF;
    logic [3:0]              stall_phase = '0;

    scenario_t plan [16] = '{
        '{1'b0, 11'd640,  12'd480,  PIX_CONST,   8'd255, 16'd16,   1'b0, 1},
        '{1'b1, 11'd7,    12'd7,    PIX_CONST,   8'd0,   16'd49,   1'b0, 1},
        '{1'b0, 11'd7,    12'd7,    PIX_IMPULSE, 8'd255, 16'd49,   1'b0, 0},
        '{1'b0, 11'd7,    12'd7,    PIX_IMPULSE, 8'd1,   16'd49,   1'b0, 0},
        '{1'b0, 11'd7,    12'd7,    PIX_RANDOM,  8'd0,   16'd49,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd8,    12'd8,    PIX_CHECKER, 8'd255, 16'd64,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd6,    12'd10,   PIX_RANDOM,  8'd0,   16'd30,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd0,    12'd10,   PIX_RANDOM,  8'd0,   16'd20,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd7,    12'd0,    PIX_RANDOM,  8'd0,   16'd21,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd7,    12'd6,    PIX_BINARY,  8'd0,   16'd42,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd2047, 12'd7,    PIX_RAMP,    8'd37,  16'd64,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd1024, 12'd8,    PIX_NEAR,    8'd128, 16'd64,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd7,    12'd4095, PIX_RANDOM,  8'd0,   16'd70,   1'b0, WHITE_PREDICTED},
        '{1'b1, 11'd12,   12'd12,   PIX_BINARY,  8'd0,   16'd144,  1'b1, WHITE_PREDICTED},
        '{1'b1, 11'd9,    12'd9,    PIX_NEAR,    8'd250, 16'd81,   1'b0, WHITE_PREDICTED},
        '{1'b0, 11'd9,    12'd9,    PIX_NEAR,    8'd3,   16'd81,   1'b0, WHITE_PREDICTED}
    };

    local_mean_adaptive_threshold #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_of_frame (s_start_of_frame),
        .s_pixel          (s_pixel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_center_col     (m_center_col),
        .m_center_row     (m_center_row),
        .m_is_white       (m_is_white),
        .m_last_of_frame  (m_last_of_frame)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    task automatic threshold_pixel(input logic sof, input pixel_t px, input int fixed_white);
        int     w, h, c, r, k, j, sum;
        pixel_t column [SPAN];
        mark_t  m;
        w = eff_width();
        h = eff_height();
        if (sof) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c = col_cnt;
        r = row_cnt;
        if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
        for (k = 0; k < LINES; k++) column[k] = line_mem[k][c];
        column[LINES] = px;
        for (k = 0; k < SPAN; k++) begin
            for (j = 0; j < SPAN - 1; j++) win[k][j] = win[k][j + 1];
            win[k][SPAN - 1] = column[k];
        end
        for (k = 0; k < LINES - 1; k++) line_mem[k][c] = line_mem[k + 1][c];
        line_mem[LINES - 1][c] = px;
        if (r >= LINES && c >= LINES) begin
            sum = 0;
            for (k = 0; k < SPAN; k++)
                for (j = 0; j < SPAN; j++) sum += win[k][j];
            m.col   = COL_OUT_W'(c - RADIUS);
            m.row   = ROW_W'(r - RADIUS);
            m.white = (win[RADIUS][RADIUS] > sum / AREA) ? 1'b0 : 1'b1;
            if (fixed_white != WHITE_PREDICTED) m.white = fixed_white[0];
            m.last  = (r == h - 1 && c == w - 1);
            pending_marks.push_back(m);
        end
        c = col_cnt + 1;
        r = row_cnt;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c & 16'hFFFF;
        row_cnt = r & 12'hFFF;
    endtask

    function automatic pixel_t pattern_pixel(pix_mode_t mode, pixel_t level, int idx, int w);
        int col, row, v;
        col = idx % w;
        row = idx / w;
        case (mode)
            PIX_CONST:   v = level;
            PIX_IMPULSE: v = (row == RADIUS && col == RADIUS) ? level : 0;
            PIX_RAMP:    v = (idx * level) & 8'hFF;
            PIX_CHECKER: v = ((row + col) % 2 == 1) ? level : 0;
            PIX_NEAR:    v = level + int'($urandom_range(0, 6)) - 3;
            PIX_BINARY:  v = ($urandom_range(0, 1) == 1) ? 255 : 0;
            default:     v = $urandom_range(0, 255);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pixel_t'(v);
    endfunction

    task automatic send_pixel(input logic sof, input pixel_t px, input int fixed_white);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 400)
                                                     : $urandom_range(1, 24);
        end
        s_valid          <= 1'b1;
        s_start_of_frame <= sof;
        s_pixel          <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        threshold_pixel(sof, px, fixed_white);
        burst_left--;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic send_phase(input pix_mode_t mode, input pixel_t level, input int pixels,
                              input logic sof_noise, input int fixed_white);
        int   i, w;
        logic sof;
        w = eff_width();
        for (i = 0; i < pixels; i++) begin
            sof = (i == 0) || (sof_noise && $urandom_range(0, 199) == 0);
            send_pixel(sof, pattern_pixel(mode, level, i, w), fixed_white);
        end
    endtask

    task automatic apply_geometry(input logic [WIDTH_REG_W-1:0] w_raw,
                                  input logic [HEIGHT_REG_W-1:0] h_raw);
        if (burst_left != 0) begin
            s_valid   <= 1'b0;
            burst_left = 0;
        end
        while (pending_marks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= {1'($urandom_range(0, 1)), w_raw};
        @(posedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h_raw;
        @(posedge aclk);
        if ($urandom_range(0, 3) == 0) begin
            cfg_index <= ($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO;
            cfg_data  <= cfg_data_t'($urandom);
            @(posedge aclk);
        end
        cfg_we    <= 1'b0;
        width_reg  = w_raw;
        height_reg = h_raw;
    endtask

    always @(posedge aclk) begin
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(32, 256);
            stall_word   = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
        stretch_left--;
        stall_phase++;
        m_ready <= stall_word[stall_phase];
    end

    always @(posedge aclk) begin
        mark_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_marks.size() == 0) begin
                $error("unrequested result: center_col %0d center_row %0d",
                       m_center_col, m_center_row);
                err_count++;
            end else begin
                want = pending_marks.pop_front();
                if (m_center_col !== want.col) begin
                    $error("center_col expected %0d actual %0d", want.col, m_center_col);
                    err_count++;
                end
                if (m_center_row !== want.row) begin
                    $error("center_row expected %0d actual %0d", want.row, m_center_row);
                    err_count++;
                end
                if (m_is_white !== want.white) begin
                    $error("is_white expected %0d actual %0d", want.white, m_is_white);
                    err_count++;
                end
                if (m_last_of_frame !== want.last) begin
                    $error("last_of_frame expected %0d actual %0d", want.last, m_last_of_frame);
                    err_count++;
                end
            end
        end
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("tb: errors");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [WIDTH_REG_W-1:0]  w_raw;
        logic [HEIGHT_REG_W-1:0] h_raw;
        int                      w, h, pixels, random_items;
        pix_mode_t               mode;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].write_geometry) apply_geometry(plan[i].width_raw, plan[i].height_raw);
            send_phase(plan[i].mode, plan[i].level, plan[i].pixels, plan[i].sof_noise,
                       plan[i].fixed_white);
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0, 1:    w_raw = $urandom_range(0, LINES);
                    2:       w_raw = $urandom_range(21, 160);
                    default: w_raw = $urandom_range(SPAN, 20);
                endcase
                h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LINES)
                                                    : $urandom_range(SPAN, 14);
                apply_geometry(w_raw, h_raw);
            end
            w = eff_width();
            h = eff_height();
            case ($urandom_range(0, 3))
                0:       pixels = $urandom_range(1, w * h);
                1:       pixels = 2 * w * h;
                default: pixels = w * h;
            endcase
            if (pixels > RANDOM_ITEMS - random_items) pixels = RANDOM_ITEMS - random_items;
            mode = pix_mode_t'($urandom_range(0, 6));
            send_phase(mode, pixel_t'($urandom), pixels, $urandom_range(0, 4) == 0,
                       WHITE_PREDICTED);
            random_items += pixels;
        end

        if (burst_left != 0) s_valid <= 1'b0;
        while (pending_marks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule
